>>> design/lfps_pkg.sv
package lfps_pkg;

  localparam int SENSOR_COUNT = 8;

  // Port and register widths
  localparam int GAIN_W     = 16;
  localparam int DUTY_W     = 10;
  localparam int THR_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int HITS_W     = 4;
  localparam int X100_W     = 11;

  // Internal arithmetic widths
  localparam int SUM_W     = 14;  // weighted sum of set bits, Q6.8
  localparam int OFF_W     = 12;  // offset and error, Q4.8
  localparam int DIFF_W    = 13;  // error difference for the derivative term
  localparam int INTEG_W   = 32;
  localparam int OPB_W     = 32;  // second operand of the shared multiplier
  localparam int PROD_W    = 49;
  localparam int PID_W     = 50;
  localparam int DIV_NUM_W = 13;  // magnitude of the weighted sum
  localparam int DIV_DEN_W = 3;   // active count when a divide is needed (1..7)

  localparam logic signed [SUM_W-1:0] WEIGHT_Q88 [SENSOR_COUNT] = '{
    14'sd1792, 14'sd1280, 14'sd768, 14'sd128,
    -14'sd384, -14'sd768, -14'sd1280, -14'sd1792
  };

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_THR     = 3'd7;

  localparam logic [DUTY_W-1:0] MAX_DUTY_RST = 10'd1000;
  localparam logic [THR_W-1:0]  SIDE_THR_RST = 11'd256;
  localparam logic [THR_W-1:0]  BIG_THR_RST  = 11'd768;

  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_LEFT    = 2'd1,
    SIDE_RIGHT   = 2'd2
  } side_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_MAC_P,
    ST_MAC_I,
    ST_MAC_D,
    ST_MAC_DRAIN,
    ST_WRITE
  } seq_state_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

>>> design/lfps_div.sv
module lfps_div import lfps_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Restoring division: one quotient bit per cycle, dividend bits shift out
  // of the top of quo while quotient bits shift in at the bottom.
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    trial   = shifted - {1'b0, den};
    fits    = (shifted >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = quo;

endmodule

>>> design/lfps_mac.sv
module lfps_mac import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic [GAIN_W-1:0]       gain,
  input  logic signed [OPB_W-1:0] operand,
  output logic signed [PID_W-1:0] acc
);

  logic signed [PROD_W-1:0] product;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ctrl.clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
  end

  // The gain is unsigned, so it gets a zero sign bit before the multiply.
  always_ff @(posedge clk) begin
    product <= $signed({1'b0, gain}) * operand;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + PID_W'(product);
    end
  end

endmodule

>>> design/line_follow_pid_steering_unit.sv
// An accepted sensor pattern takes its longest path when only some sensors see the line:
// the 13-step divider and then three passes through the shared multiply-accumulate unit.
// When every sensor sees the line the divider is skipped, and when none does the pattern
// goes straight to the output write. One pattern is worked on at a time (in_stall is high outside ST_IDLE).
// Reset (rst, synchronous) restores the register defaults, clears the PID memory,
// the side memory and the search flag, and empties the output register.
module line_follow_pid_steering_unit import lfps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SENSOR_COUNT-1:0]  sensor_bits,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DUTY_W-1:0]        left_duty,
  output logic [DUTY_W-1:0]        right_duty,
  output logic                     no_line,
  output logic                     big_turn,
  output logic signed [X100_W-1:0] offset_x100,
  output logic [HITS_W-1:0]        active_sensors,
  output logic [SENSOR_COUNT-1:0]  raw_pattern
);

  localparam int VAL_W = PID_W + 1;
  localparam int Q_W   = VAL_W - 16;

  function automatic logic [DUTY_W-1:0] duty_from(input logic signed [VAL_W-1:0] v,
                                                  input logic [DUTY_W-1:0] max_d);
    logic [Q_W-1:0] q;
    q = v[VAL_W-1:16];
    if (v[VAL_W-1]) begin
      return '0;
    end else if (q > Q_W'(max_d)) begin
      return max_d;
    end else begin
      return q[DUTY_W-1:0];
    end
  endfunction

  // offset * 100 / 256, truncated toward zero
  function automatic logic [X100_W-1:0] x100(input logic signed [OFF_W-1:0] off);
    logic signed [18:0] p;
    logic signed [18:0] adj;
    p   = $signed({{(19-OFF_W){off[OFF_W-1]}}, off}) * 19'sd100;
    adj = p[18] ? p + 19'sd255 : p;
    return adj[18:8];
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [DUTY_W-1:0] base_duty, search_duty, max_duty;
  logic [THR_W-1:0]  side_threshold, big_turn_threshold;

  // Loop state
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [OFF_W-1:0]   previous_error;
  logic signed [OFF_W-1:0]   last_valid_offset;
  side_t                     remembered_side;
  logic                      searching;

  // Per-item working registers
  seq_state_t                state, state_next;
  logic [SENSOR_COUNT-1:0]   pattern;
  logic signed [SUM_W-1:0]   wsum;
  logic [HITS_W-1:0]         hits;
  logic signed [OFF_W-1:0]   off;
  logic signed [OFF_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic                      lost;
  logic                      big;

  logic signed [SUM_W-1:0]   wsum_c;
  logic [HITS_W-1:0]         hits_c;
  logic                      in_accept;
  logic                      out_load;

  logic                      div_start, div_done;
  logic [DIV_NUM_W-1:0]      div_quo;
  logic [SUM_W-1:0]          wsum_mag;

  mac_ctrl_t                 mac_ctrl;
  logic [GAIN_W-1:0]         mac_gain;
  logic signed [OPB_W-1:0]   mac_operand;
  logic signed [PID_W-1:0]   pid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= '0;
      gain_i             <= '0;
      gain_d             <= '0;
      base_duty          <= '0;
      search_duty        <= '0;
      max_duty           <= MAX_DUTY_RST;
      side_threshold     <= SIDE_THR_RST;
      big_turn_threshold <= BIG_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_P:      gain_p             <= cfg_data;
        CFG_GAIN_I:      gain_i             <= cfg_data;
        CFG_GAIN_D:      gain_d             <= cfg_data;
        CFG_BASE_DUTY:   base_duty          <= cfg_data[DUTY_W-1:0];
        CFG_SEARCH_DUTY: search_duty        <= cfg_data[DUTY_W-1:0];
        CFG_MAX_DUTY:    max_duty           <= cfg_data[DUTY_W-1:0];
        CFG_SIDE_THR:    side_threshold     <= cfg_data[THR_W-1:0];
        CFG_BIG_THR:     big_turn_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wsum_c = '0;
    hits_c = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (sensor_bits[i]) begin
        wsum_c = wsum_c + WEIGHT_Q88[i];
        hits_c = hits_c + HITS_W'(1);
      end
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_WRITE) && (!out_valid || !out_stall);
  assign wsum_mag  = wsum[SUM_W-1] ? -wsum : wsum;

  lfps_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (wsum_mag[DIV_NUM_W-1:0]),
    .denom    (hits[DIV_DEN_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  lfps_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mac_ctrl),
    .gain    (mac_gain),
    .operand (mac_operand),
    .acc     (pid)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    div_start   = 1'b0;
    mac_ctrl    = '0;
    mac_gain    = '0;
    mac_operand = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (hits_c == '0) begin
            state_next = ST_WRITE;
          end else if (hits_c == HITS_W'(SENSOR_COUNT)) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mac_ctrl.clear = 1'b1;
        state_next     = ST_MAC_P;
      end
      ST_MAC_P: begin
        mac_ctrl.issue = 1'b1;
        mac_gain       = gain_p;
        mac_operand    = OPB_W'(err);
        state_next     = ST_MAC_I;
      end
      ST_MAC_I: begin
        mac_ctrl.issue = 1'b1;
        mac_gain       = gain_i;
        mac_operand    = integral_sum;
        state_next     = ST_MAC_D;
      end
      ST_MAC_D: begin
        mac_ctrl.issue = 1'b1;
        mac_gain       = gain_d;
        mac_operand    = OPB_W'(diff);
        state_next     = ST_MAC_DRAIN;
      end
      ST_MAC_DRAIN: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Update-step arithmetic, used in ST_UPDATE; off_div is used when the divide finishes
  logic signed [OFF_W-1:0]     err_c;
  logic signed [OFF_W-1:0]     prev_c;
  logic signed [INTEG_W-1:0]   ibase;
  logic signed [INTEG_W:0]     isum;
  logic signed [INTEG_W-1:0]   isat;
  logic signed [DIFF_W-1:0]    off_w;
  logic signed [DIFF_W-1:0]    side_thr_w;
  logic [OFF_W-1:0]            mag;
  logic signed [OFF_W-1:0]     off_div;

  always_comb begin
    err_c  = -off;
    // On reacquiring the line the PID memory restarts from this error.
    prev_c = searching ? err_c : previous_error;
    ibase  = searching ? '0 : integral_sum;
    isum   = (INTEG_W+1)'(ibase) + (INTEG_W+1)'(err_c);
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      isat = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      isat = isum[INTEG_W-1:0];
    end
    off_w      = DIFF_W'(off);
    side_thr_w = $signed({{(DIFF_W-THR_W){1'b0}}, side_threshold});
    mag        = off[OFF_W-1] ? -off : off;
    off_div    = $signed({1'b0, div_quo[OFF_W-2:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum      <= '0;
      previous_error    <= '0;
      last_valid_offset <= '0;
      remembered_side   <= SIDE_UNKNOWN;
      searching         <= 1'b0;
    end else if (in_accept && hits_c == '0) begin
      searching    <= 1'b1;
      integral_sum <= '0;
    end else if (state == ST_UPDATE) begin
      searching         <= 1'b0;
      integral_sum      <= isat;
      previous_error    <= err_c;
      last_valid_offset <= off;
      if (off_w > side_thr_w) begin
        remembered_side <= SIDE_LEFT;
      end else if (off_w < -side_thr_w) begin
        remembered_side <= SIDE_RIGHT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pattern <= sensor_bits;
      wsum    <= wsum_c;
      hits    <= hits_c;
      lost    <= (hits_c == '0);
      big     <= (hits_c == '0);
      off     <= '0;
    end else if (state == ST_DIV_WAIT && div_done) begin
      off <= wsum[SUM_W-1] ? -off_div : off_div;
    end else if (state == ST_UPDATE) begin
      err  <= err_c;
      diff <= DIFF_W'(err_c) - DIFF_W'(prev_c);
      big  <= ({1'b0, mag} >= (OFF_W+1)'(big_turn_threshold));
    end
  end

  // Result stage
  logic signed [VAL_W-1:0] base_w;
  logic signed [VAL_W-1:0] pid_w;
  logic [DUTY_W-1:0]       left_c, right_c;

  always_comb begin
    base_w = $signed({{(VAL_W-DUTY_W-16){1'b0}}, base_duty, 16'd0});
    pid_w  = VAL_W'(pid);
    if (lost) begin
      unique case (remembered_side)
        SIDE_LEFT: begin
          left_c  = '0;
          right_c = search_duty;
        end
        SIDE_RIGHT: begin
          left_c  = search_duty;
          right_c = '0;
        end
        default: begin
          left_c  = '0;
          right_c = '0;
        end
      endcase
    end else begin
      left_c  = duty_from(base_w + pid_w, max_duty);
      right_c = duty_from(base_w - pid_w, max_duty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_duty      <= left_c;
      right_duty     <= right_c;
      no_line        <= lost;
      big_turn       <= big;
      offset_x100    <= x100(last_valid_offset);
      active_sensors <= hits;
      raw_pattern    <= pattern;
    end
  end

  a_lost_clears_integral: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && sensor_bits == '0) |=> (searching && integral_sum == '0))
    else $error("lost line did not clear the integral");

  a_search_integral_zero: assert property (@(posedge clk) disable iff (rst)
    searching |-> (integral_sum == '0))
    else $error("integral nonzero while searching");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_write_completes: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("result load did not complete the transaction");

endmodule
